@@ design/tccs_pkg.sv @@
// shared types and constants of the text console
`default_nettype none

package tccs_pkg;

	localparam int unsigned KIND_W = 1;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned ATTR_W = 8;
	localparam int unsigned CELL_W = CHAR_W + ATTR_W;
	localparam int unsigned ROW_IN_W = 5;
	localparam int unsigned COL_IN_W = 7;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [ATTR_W-1:0] RESET_COLOR = 8'd15;

	localparam logic KIND_PUT = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [APB_ADDR_W-1:0] REG_TEXT_COLOR = 3'd0;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_PUT,
		WR_COPY,
		WR_BLANK,
		WR_CLEAR
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_ITEM,
		RD_COPY
	} rd_sel_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic ptr_clr;
		logic ptr_inc;
		logic out_load;
		logic out_nxt;
		wr_sel_t wr_sel;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic kind_rd;
		logic plain;
		logic need_scroll;
		logic ptr_last_copy;
		logic ptr_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ design/text_console_cursor_scroll_top.sv @@
// top level of the text console: register port, controller and datapath
//
// Text screen of COLS x ROWS 16-bit cells (character low byte, attribute high
// byte) with a cursor. A put beat of an ordinary character, a newline or a
// carriage return has its result loaded in EXEC, or in DONE if the output is
// full; a read beat reads the screen memory in EXEC and loads the registered
// read data in DONE. A put that scrolls copies the screen one row up through
// that same memory, reading each cell in SC_RD and writing it in SC_WR, then
// blanks the bottom row one cell per cycle. After reset a clearing pass writes
// blanks to all COLS*ROWS cells, one per cycle, before the first beat is
// accepted; text_color can be written during that pass. A finished result
// waits in an output register, so the next beat is taken while it is held.
`default_nettype none

module text_console_cursor_scroll_top #(
	parameter int unsigned COLS = 80,
	parameter int unsigned ROWS = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tccs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [tccs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [tccs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tccs_pkg::KIND_W-1:0]       kind,
	input  logic [tccs_pkg::CHAR_W-1:0]       char_code,
	input  logic [tccs_pkg::ROW_IN_W-1:0]     cell_row,
	input  logic [tccs_pkg::COL_IN_W-1:0]     cell_col,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tccs_pkg::CELL_W-1:0]       cell_word,
	output logic [tccs_pkg::COL_IN_W-1:0]     cursor_col,
	output logic [tccs_pkg::ROW_IN_W-1:0]     cursor_row,
	output logic                              scrolled
);
	import tccs_pkg::*;

	logic [ATTR_W-1:0] color_q;
	logic              reg_hit;
	cmd_t              cmd;
	sts_t              sts;

	// word-aligned register decode
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_TEXT_COLOR[APB_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign prdata = reg_hit ? APB_DATA_W'(color_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_COLOR;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			color_q <= pwdata[ATTR_W-1:0];
		end
	end

	tccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tccs_dpath #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (kind),
		.char_code  (char_code),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.text_color (color_q),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_word  (cell_word),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.scrolled   (scrolled)
	);

endmodule

`default_nettype wire

@@ design/tccs_ctrl.sv @@
// controller state machine of the text console
`default_nettype none

module tccs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tccs_pkg::sts_t sts,
	output tccs_pkg::cmd_t cmd
);
	import tccs_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SC_RD,
		ST_SC_WR,
		ST_BLANK,
		ST_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.wr_sel = WR_NONE;
		cmd.rd_sel = RD_NONE;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_sel = WR_CLEAR;
				cmd.ptr_inc = 1'b1;
			end
			ST_IDLE: begin
				cmd.accept = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.kind_rd) begin
					cmd.rd_sel = RD_ITEM;
				end else begin
					if (sts.plain) begin
						cmd.wr_sel = WR_PUT;
					end
					if (sts.need_scroll) begin
						cmd.ptr_clr = 1'b1;
					end else if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_nxt = 1'b1;
					end
				end
			end
			ST_SC_RD: begin
				cmd.rd_sel = RD_COPY;
			end
			ST_SC_WR: begin
				cmd.wr_sel = WR_COPY;
				cmd.ptr_inc = 1'b1;
			end
			ST_BLANK: begin
				cmd.wr_sel = WR_BLANK;
				cmd.ptr_inc = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.ptr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (sts.kind_rd) state_q <= ST_DONE;
					else if (sts.need_scroll) state_q <= ST_SC_RD;
					else if (sts.out_free) state_q <= ST_IDLE;
					else state_q <= ST_DONE;
				end
				ST_SC_RD: begin
					state_q <= ST_SC_WR;
				end
				ST_SC_WR: begin
					if (sts.ptr_last_copy) state_q <= ST_BLANK;
					else state_q <= ST_SC_RD;
				end
				ST_BLANK: begin
					if (sts.ptr_last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/tccs_dpath.sv @@
// screen memory, cursor, scan pointer and result register of the text console
`default_nettype none

module tccs_dpath #(
	parameter int unsigned COLS = 80,
	parameter int unsigned ROWS = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [tccs_pkg::KIND_W-1:0]     kind,
	input  logic [tccs_pkg::CHAR_W-1:0]     char_code,
	input  logic [tccs_pkg::ROW_IN_W-1:0]   cell_row,
	input  logic [tccs_pkg::COL_IN_W-1:0]   cell_col,
	input  logic [tccs_pkg::ATTR_W-1:0]     text_color,
	input  tccs_pkg::cmd_t                  cmd,
	output tccs_pkg::sts_t                  sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tccs_pkg::CELL_W-1:0]     cell_word,
	output logic [tccs_pkg::COL_IN_W-1:0]   cursor_col,
	output logic [tccs_pkg::ROW_IN_W-1:0]   cursor_row,
	output logic                            scrolled
);
	import tccs_pkg::*;

	localparam int unsigned CELLS = COLS * ROWS;
	localparam int unsigned ADDR_W = $clog2(CELLS);
	localparam int unsigned COL_W = $clog2(COLS);
	localparam int unsigned ROW_W = $clog2(ROWS);

	logic [CELL_W-1:0] screen_q [CELLS];
	logic [CELL_W-1:0] rd_q;

	logic              kind_q;
	logic [CHAR_W-1:0] char_q;
	logic [ROW_IN_W-1:0] rrow_q;
	logic [COL_IN_W-1:0] rcol_q;

	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              scr_q;

	logic                out_valid_q;
	logic [CELL_W-1:0]   word_q;
	logic [COL_IN_W-1:0] ocol_q;
	logic [ROW_IN_W-1:0] orow_q;
	logic                oscr_q;

	logic              is_nl;
	logic              is_cr;
	logic              plain;
	logic              col_end;
	logic              row_end;
	logic              adv_row;
	logic              need_scroll;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic              rd_ok;
	logic [ADDR_W-1:0] item_addr;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] src_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CELL_W-1:0] wr_data;

	assign is_nl = (char_q == CH_NEWLINE);
	assign is_cr = (char_q == CH_RETURN);
	assign plain = !is_nl && !is_cr;
	assign col_end = (cur_col_q == COL_W'(COLS - 1));
	assign row_end = (cur_row_q == ROW_W'(ROWS - 1));
	assign adv_row = is_nl || (plain && col_end);
	assign need_scroll = adv_row && row_end;
	assign nxt_col = (plain && !col_end) ? cur_col_q + COL_W'(1) : '0;
	assign nxt_row = (adv_row && !row_end) ? cur_row_q + ROW_W'(1) : cur_row_q;

	assign rd_ok = (32'(rrow_q) < 32'(ROWS)) && (32'(rcol_q) < 32'(COLS));
	assign item_addr = ADDR_W'(32'(rrow_q) * 32'(COLS) + 32'(rcol_q));
	assign cur_addr = ADDR_W'(32'(cur_row_q) * 32'(COLS) + 32'(cur_col_q));
	assign src_addr = ptr_q + ADDR_W'(COLS);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = src_addr;
		case (cmd.rd_sel)
			RD_ITEM: begin
				rd_en = rd_ok;
				rd_addr = item_addr;
			end
			RD_COPY: begin
				rd_en = 1'b1;
				rd_addr = src_addr;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en = 1'b1;
		wr_addr = ptr_q;
		wr_data = rd_q;
		case (cmd.wr_sel)
			WR_PUT: begin
				wr_addr = cur_addr;
				wr_data = {text_color, char_q};
			end
			WR_COPY: begin
				wr_data = rd_q;
			end
			WR_BLANK: begin
				wr_data = {text_color, CH_SPACE};
			end
			WR_CLEAR: begin
				wr_data = {RESET_COLOR, CH_SPACE};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) screen_q[wr_addr] <= wr_data;
		if (rd_en) rd_q <= screen_q[rd_addr];
	end

	// input beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= (kind == KIND_READ);
			char_q <= char_code;
			rrow_q <= cell_row;
			rcol_q <= cell_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			ptr_q <= '0;
			scr_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				scr_q <= !kind_q && need_scroll;
				if (!kind_q) begin
					cur_col_q <= nxt_col;
					cur_row_q <= nxt_row;
				end
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + ADDR_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			word_q <= (kind_q && rd_ok) ? rd_q : '0;
			if (cmd.out_nxt) begin
				ocol_q <= COL_IN_W'(nxt_col);
				orow_q <= ROW_IN_W'(nxt_row);
				oscr_q <= 1'b0;
			end else begin
				ocol_q <= COL_IN_W'(cur_col_q);
				orow_q <= ROW_IN_W'(cur_row_q);
				oscr_q <= scr_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign cell_word = word_q;
	assign cursor_col = ocol_q;
	assign cursor_row = orow_q;
	assign scrolled = oscr_q;

	assign sts.kind_rd = kind_q;
	assign sts.plain = plain;
	assign sts.need_scroll = need_scroll;
	assign sts.ptr_last_copy = (ptr_q == ADDR_W'(CELLS - COLS - 1));
	assign sts.ptr_last = (ptr_q == ADDR_W'(CELLS - 1));
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire
